// ===== design/lr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

   localparam int CoordBits = 10;
   localparam int ErrBits   = CoordBits + 2;
   localparam int LeftBits  = CoordBits + 1;
   localparam int ColorBits = 16;

   typedef logic [CoordBits-1:0] coord_type;
   typedef logic [ErrBits-1:0]   err_type;
   typedef logic [LeftBits-1:0]  left_type;
   typedef logic [ColorBits-1:0] color_type;

   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_INC  = 2'd1,
      STEP_DEC  = 2'd3
   } step_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } opcode_type;

endpackage

`default_nettype wire

// ===== design/line_rasterizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Line rasterizer: a load word (opcode 0) takes both endpoints and gives no
// pixel; each following step word (opcode 1) gives one pixel, major distance
// plus two in all, the start pixel twice and the final one flagged with
// rsp_last_pixel. A word is taken every cycle while the result register is
// free or being drained; each pixel shows in the cycle after its step word,
// since the error update is one add, compare and subtract per axis on
// registered state. A step with no line loaded gives nothing; a load
// restarts the walk. pen color is sampled when the step word is taken.
module line_rasterizer (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_we,
   input  wire [lr_pkg::ColorBits-1:0] csr_wdata,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire                        req_opcode,
   input  wire [lr_pkg::CoordBits-1:0] req_start_x,
   input  wire [lr_pkg::CoordBits-1:0] req_start_y,
   input  wire [lr_pkg::CoordBits-1:0] req_end_x,
   input  wire [lr_pkg::CoordBits-1:0] req_end_y,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [lr_pkg::CoordBits-1:0] rsp_pixel_x,
   output logic [lr_pkg::CoordBits-1:0] rsp_pixel_y,
   output logic [lr_pkg::ColorBits-1:0] rsp_pixel_color,
   output logic                       rsp_last_pixel
);

   lr_pkg::color_type pen_color_ff, pen_color_in;
   lr_pkg::coord_type cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   lr_pkg::err_type   err_x_ff, err_x_in, err_y_ff, err_y_in;
   lr_pkg::coord_type abs_dx_ff, abs_dx_in, abs_dy_ff, abs_dy_in;
   lr_pkg::coord_type major_ff, major_in;
   lr_pkg::step_type  step_x_ff, step_x_in, step_y_ff, step_y_in;
   lr_pkg::left_type  left_ff, left_in;
   logic              busy_ff, busy_in;

   logic              rsp_valid_ff, rsp_valid_in;
   lr_pkg::coord_type rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   lr_pkg::color_type rsp_color_ff, rsp_color_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   lr_pkg::err_type   sum_x, sum_y, major_ext;
   lr_pkg::coord_type dx, dy;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pen_color_in = csr_we ? csr_wdata : pen_color_ff;

      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      err_x_in  = err_x_ff;
      err_y_in  = err_y_ff;
      abs_dx_in = abs_dx_ff;
      abs_dy_in = abs_dy_ff;
      major_in  = major_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      left_in   = left_ff;
      busy_in   = busy_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;

      major_ext = {2'b00, major_ff};
      sum_x     = err_x_ff + {2'b00, abs_dx_ff};
      sum_y     = err_y_ff + {2'b00, abs_dy_ff};

      // endpoint deltas and directions for a load
      if (req_end_x > req_start_x) begin
         dx        = req_end_x - req_start_x;
         step_x_in = lr_pkg::STEP_INC;
      end else if (req_end_x == req_start_x) begin
         dx        = '0;
         step_x_in = lr_pkg::STEP_NONE;
      end else begin
         dx        = req_start_x - req_end_x;
         step_x_in = lr_pkg::STEP_DEC;
      end
      if (req_end_y > req_start_y) begin
         dy        = req_end_y - req_start_y;
         step_y_in = lr_pkg::STEP_INC;
      end else if (req_end_y == req_start_y) begin
         dy        = '0;
         step_y_in = lr_pkg::STEP_NONE;
      end else begin
         dy        = req_start_y - req_end_y;
         step_y_in = lr_pkg::STEP_DEC;
      end
      if (!(accept && (req_opcode == lr_pkg::OP_LOAD))) begin
         step_x_in = step_x_ff;
         step_y_in = step_y_ff;
      end

      if (accept && (req_opcode == lr_pkg::OP_LOAD)) begin
         abs_dx_in = dx;
         abs_dy_in = dy;
         major_in  = (dx > dy) ? dx : dy;
         cur_x_in  = req_start_x;
         cur_y_in  = req_start_y;
         err_x_in  = '0;
         err_y_in  = '0;
         left_in   = {1'b0, major_in} + lr_pkg::left_type'(2);
         busy_in   = 1'b1;
      end else if (accept && busy_ff) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = cur_x_ff;
         rsp_y_in     = cur_y_ff;
         rsp_color_in = pen_color_ff;
         rsp_last_in  = (left_ff == lr_pkg::left_type'(1));

         err_x_in = sum_x;
         if (sum_x > major_ext) begin
            err_x_in = sum_x - major_ext;
            case (step_x_ff)
               lr_pkg::STEP_INC: cur_x_in = cur_x_ff + lr_pkg::coord_type'(1);
               lr_pkg::STEP_DEC: cur_x_in = cur_x_ff - lr_pkg::coord_type'(1);
               default:          cur_x_in = cur_x_ff;
            endcase
         end
         err_y_in = sum_y;
         if (sum_y > major_ext) begin
            err_y_in = sum_y - major_ext;
            case (step_y_ff)
               lr_pkg::STEP_INC: cur_y_in = cur_y_ff + lr_pkg::coord_type'(1);
               lr_pkg::STEP_DEC: cur_y_in = cur_y_ff - lr_pkg::coord_type'(1);
               default:          cur_y_in = cur_y_ff;
            endcase
         end

         if (left_ff != '0) begin
            left_in = left_ff - lr_pkg::left_type'(1);
         end
         busy_in = (left_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_color_ff <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         err_x_ff     <= '0;
         err_y_ff     <= '0;
         abs_dx_ff    <= '0;
         abs_dy_ff    <= '0;
         major_ff     <= '0;
         step_x_ff    <= lr_pkg::STEP_NONE;
         step_y_ff    <= lr_pkg::STEP_NONE;
         left_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pen_color_ff <= pen_color_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         err_x_ff     <= err_x_in;
         err_y_ff     <= err_y_in;
         abs_dx_ff    <= abs_dx_in;
         abs_dy_ff    <= abs_dy_in;
         major_ff     <= major_in;
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         left_ff      <= left_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   // idle walk has nothing left to emit
   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (left_ff == '0))
      else $error("idle with pixels left");

   // error sums never pass the major distance
   assert property (@(posedge clock) disable iff (reset)
      (err_x_ff <= {2'b00, major_ff}) && (err_y_ff <= {2'b00, major_ff}))
      else $error("error sum out of range");

   // a step on a live walk always yields a pixel next cycle
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == lr_pkg::OP_STEP) && busy_ff) |=> rsp_valid_ff)
      else $error("step word lost");

   // the flagged pixel ends the walk
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == lr_pkg::OP_STEP) && busy_ff
       && (left_ff == lr_pkg::left_type'(1))) |=> (!busy_ff && rsp_last_ff))
      else $error("walk did not end on last pixel");

endmodule

`default_nettype wire
